/* design/utg_pkg.sv */
// Shared widths, codes and table entry type for the UTF-8 to glyph index decoder.
package utg_pkg;

    // Field widths
    localparam int FUNC_W   = 1;
    localparam int SLOT_W   = 4;
    localparam int CODE_W   = 16;
    localparam int GLYPH_W  = 17;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 5;
    localparam int LEFT_W   = 2;

    // Operation codes on the input channel
    localparam logic [FUNC_W-1:0] FUNC_TABLE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_TEXT  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOMATCH  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FOURBYTE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BADLEAD  = 2'd3;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // Continuation bytes still expected
    localparam logic [LEFT_W-1:0] LEFT_NONE  = 2'd0;
    localparam logic [LEFT_W-1:0] LEFT_ONE   = 2'd1;
    localparam logic [LEFT_W-1:0] LEFT_TWO   = 2'd2;
    localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

    // Payload bit positions
    localparam int SHIFT_MID = 6;
    localparam int SHIFT_HI  = 12;

    // One range table entry
    typedef struct packed {
        logic [CODE_W-1:0] first_code;
        logic [CODE_W-1:0] length;
        logic [CODE_W-1:0] first_glyph;
    } t_range_entry;

endpackage

/* design/utg_in_if.sv */
// Input channel: table entry writes and text bytes with valid/ready handshake.
interface utg_in_if;
    logic                         valid;
    logic                         ready;
    logic [utg_pkg::FUNC_W-1:0]   func;
    logic [utg_pkg::SLOT_W-1:0]   entry_slot;
    logic [utg_pkg::CODE_W-1:0]   range_first_code;
    logic [utg_pkg::CODE_W-1:0]   range_length;
    logic [utg_pkg::CODE_W-1:0]   range_first_glyph;
    logic [utg_pkg::BYTE_W-1:0]   text_byte;

    modport source (
        output valid, func, entry_slot, range_first_code, range_length,
               range_first_glyph, text_byte,
        input  ready
    );
    modport sink (
        input  valid, func, entry_slot, range_first_code, range_length,
               range_first_glyph, text_byte,
        output ready
    );
endinterface

/* design/utg_out_if.sv */
// Output channel: decoded code point results with valid/ready handshake.
interface utg_out_if;
    logic                          valid;
    logic                          ready;
    logic [utg_pkg::CODE_W-1:0]    code_point;
    logic [utg_pkg::GLYPH_W-1:0]   glyph_index;
    logic [utg_pkg::STATUS_W-1:0]  status;
    logic [utg_pkg::LEN_W-1:0]     sequence_length;

    modport source (
        output valid, code_point, glyph_index, status, sequence_length,
        input  ready
    );
    modport sink (
        input  valid, code_point, glyph_index, status, sequence_length,
        output ready
    );
endinterface

/* design/utf8_to_glyph_index_core.sv */
// A table write or a byte that does not end a sequence leaves the decoder idle and ready.
// A byte that ends a 1- to 3-byte sequence walks the range table with one shared comparator
// fed by a registered read over at most min(range_count, TABLE_ENTRIES) entries (an early
// match ends the walk sooner); the result then waits in ST_FINISH for the output register.
// Four-byte and invalid-lead results skip the walk and go straight to ST_FINISH.
// Synchronous active-low reset clears decoder, range_count and output valid; table undefined.
module utf8_to_glyph_index_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [utg_pkg::CFG_W-1:0]     i_cfg_wdata,
    utg_in_if.sink                        i_in_ch,
    utg_out_if.source                     o_out_ch
);
    import utg_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SLX_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Registers
    logic [1:0]            r_state,        n_state;
    logic [CFG_W-1:0]      r_range_count;
    logic [CODE_W-1:0]     r_accum,        n_accum;
    logic [LEFT_W-1:0]     r_left,         n_left;
    logic [LEN_W-1:0]      r_seqlen,       n_seqlen;
    logic [CODE_W-1:0]     r_cp,           n_cp;
    logic [CNT_W-1:0]      r_idx,          n_idx;
    logic [CNT_W-1:0]      r_limit,        n_limit;
    logic                  r_ent_vld,      n_ent_vld;
    t_range_entry          r_ent;
    logic [GLYPH_W-1:0]    r_res_glyph,    n_res_glyph;
    logic [STATUS_W-1:0]   r_res_status,   n_res_status;
    logic                  r_out_vld,      n_out_vld;
    logic [CODE_W-1:0]     r_out_cp,       n_out_cp;
    logic [GLYPH_W-1:0]    r_out_glyph,    n_out_glyph;
    logic [STATUS_W-1:0]   r_out_status,   n_out_status;
    logic [LEN_W-1:0]      r_out_len,      n_out_len;

    t_range_entry          r_table [TABLE_ENTRIES];

    // Handshake and write decode
    logic                  in_fire;
    logic                  text_fire;
    logic                  table_we;
    logic [SLX_W-1:0]      slot_ext;
    t_range_entry          wr_entry;
    logic                  out_free;
    logic                  issue;
    logic [BYTE_W-1:0]     tb;
    logic [CODE_W-1:0]     cont_bits;
    logic [CODE_W-1:0]     cont_acc;
    logic [LIM_W-1:0]      cnt_ext;
    logic [LIM_W-1:0]      lim_sat;

    // Shared range comparator
    logic [GLYPH_W-1:0]    range_end;
    logic                  hit;
    logic [GLYPH_W-1:0]    glyph_calc;

    assign i_in_ch.ready = (r_state == ST_IDLE);
    assign in_fire       = i_in_ch.valid && i_in_ch.ready;
    assign text_fire     = in_fire && (i_in_ch.func == FUNC_TEXT);
    assign slot_ext      = SLX_W'(i_in_ch.entry_slot);
    assign table_we      = in_fire && (i_in_ch.func == FUNC_TABLE)
                           && (32'(i_in_ch.entry_slot) < TABLE_ENTRIES);
    assign wr_entry      = '{first_code:  i_in_ch.range_first_code,
                             length:      i_in_ch.range_length,
                             first_glyph: i_in_ch.range_first_glyph};
    assign out_free      = !r_out_vld || o_out_ch.ready;
    assign issue         = (r_state == ST_SEARCH) && (r_idx != r_limit);
    assign tb            = i_in_ch.text_byte;

    // Merge a continuation byte with only bit 7 cleared
    assign cont_bits = CODE_W'(tb[6:0]);
    assign cont_acc  = r_accum | ((r_left == LEFT_TWO) ? (cont_bits << SHIFT_MID)
                                                       : cont_bits);

    // Clamp the search length to the table depth
    assign cnt_ext = LIM_W'(r_range_count);
    assign lim_sat = (cnt_ext > LIM_W'(TABLE_ENTRIES)) ? LIM_W'(TABLE_ENTRIES) : cnt_ext;

    // Compare one entry against the code point
    assign range_end  = {1'b0, r_ent.first_code} + {1'b0, r_ent.length};
    assign hit        = r_ent_vld && (r_ent.first_code <= r_cp)
                        && ({1'b0, r_cp} < range_end);
    assign glyph_calc = {1'b0, r_cp - r_ent.first_code} + {1'b0, r_ent.first_glyph};

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_accum      = r_accum;
        n_left       = r_left;
        n_seqlen     = r_seqlen;
        n_cp         = r_cp;
        n_idx        = r_idx;
        n_limit      = r_limit;
        n_ent_vld    = r_ent_vld;
        n_res_glyph  = r_res_glyph;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld;
        n_out_cp     = r_out_cp;
        n_out_glyph  = r_out_glyph;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;

        // Drop the result once taken
        if (r_out_vld && o_out_ch.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (text_fire) begin
                    if (r_left != LEFT_NONE) begin
                        // Continuation byte inside a sequence
                        if (r_seqlen != LEN_FOUR) begin
                            n_accum = cont_acc;
                        end
                        n_left = r_left - LEFT_ONE;
                        if (r_left == LEFT_ONE) begin
                            if (r_seqlen == LEN_FOUR) begin
                                n_res_glyph  = '0;
                                n_res_status = STAT_FOURBYTE;
                                n_state      = ST_FINISH;
                            end else begin
                                n_cp      = cont_acc;
                                n_idx     = '0;
                                n_limit   = lim_sat[CNT_W-1:0];
                                n_ent_vld = 1'b0;
                                n_state   = ST_SEARCH;
                            end
                        end
                    end else if (tb[7] == 1'b0) begin
                        // Single-byte character
                        n_accum   = CODE_W'(tb);
                        n_seqlen  = LEN_ONE;
                        n_cp      = CODE_W'(tb);
                        n_idx     = '0;
                        n_limit   = lim_sat[CNT_W-1:0];
                        n_ent_vld = 1'b0;
                        n_state   = ST_SEARCH;
                    end else if (tb[7:5] == 3'b110) begin
                        n_accum  = CODE_W'(tb[4:0]) << SHIFT_MID;
                        n_seqlen = LEN_TWO;
                        n_left   = LEFT_ONE;
                    end else if (tb[7:4] == 4'b1110) begin
                        n_accum  = CODE_W'(tb[3:0]) << SHIFT_HI;
                        n_seqlen = LEN_THREE;
                        n_left   = LEFT_TWO;
                    end else if (tb[7:3] == 5'b11110) begin
                        n_accum  = '0;
                        n_seqlen = LEN_FOUR;
                        n_left   = LEFT_THREE;
                    end else begin
                        // Stray continuation or invalid lead
                        n_accum      = '0;
                        n_seqlen     = LEN_ONE;
                        n_res_glyph  = '0;
                        n_res_status = STAT_BADLEAD;
                        n_state      = ST_FINISH;
                    end
                end
            end
            ST_SEARCH: begin
                // Advance the read one entry ahead of the compare
                n_ent_vld = issue;
                if (issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (hit) begin
                    n_res_glyph  = glyph_calc;
                    n_res_status = STAT_OK;
                    n_state      = ST_FINISH;
                end else if (r_idx == r_limit) begin
                    n_res_glyph  = '0;
                    n_res_status = STAT_NOMATCH;
                    n_state      = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold until the result register is free
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_cp     = (r_res_status == STAT_OK) ? r_cp : '0;
                    n_out_glyph  = r_res_glyph;
                    n_out_status = r_res_status;
                    n_out_len    = r_seqlen;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_range_count <= '0;
            r_accum       <= '0;
            r_left        <= LEFT_NONE;
            r_seqlen      <= '0;
            r_ent_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_accum   <= n_accum;
            r_left    <= n_left;
            r_seqlen  <= n_seqlen;
            r_ent_vld <= n_ent_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_range_count <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cp         <= n_cp;
        r_idx        <= n_idx;
        r_limit      <= n_limit;
        r_res_glyph  <= n_res_glyph;
        r_res_status <= n_res_status;
        r_out_cp     <= n_out_cp;
        r_out_glyph  <= n_out_glyph;
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
    end

    // Range table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (table_we) begin
            r_table[slot_ext[IDX_W-1:0]] <= wr_entry;
        end
        if (issue) begin
            r_ent <= r_table[r_idx[IDX_W-1:0]];
        end
    end

    assign o_out_ch.valid           = r_out_vld;
    assign o_out_ch.code_point      = r_out_cp;
    assign o_out_ch.glyph_index     = r_out_glyph;
    assign o_out_ch.status          = r_out_status;
    assign o_out_ch.sequence_length = r_out_len;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && (o_out_ch.status != STAT_OK))
        |-> (o_out_ch.code_point == '0) && (o_out_ch.glyph_index == '0))
        else $error("non-ok result carries nonzero code point or glyph");

    a_four_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && (o_out_ch.status == STAT_FOURBYTE))
        |-> (o_out_ch.sequence_length == LEN_FOUR))
        else $error("four-byte status without length four");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_idx <= r_limit))
        else $error("search index ran past the limit");

    a_ascii_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (text_fire && (r_left == LEFT_NONE) && !i_in_ch.text_byte[7])
        |=> (r_state == ST_SEARCH))
        else $error("single-byte character did not start a table walk");
`endif

endmodule
